### design/ssd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the segment distance kernel.
// No dependencies.
package ssd_pkg;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned DistBits = 36;
endpackage

### design/ssd_pt_seg.sv
`timescale 1ns / 1ps
// Pipelined point-to-segment squared distance (stages P0..P3 plus divider).
// Depends on ssd_pkg; stall control comes from the top level.
module ssd_pt_seg #(
  parameter int unsigned CoordBits = ssd_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [CoordBits-1:0]   sx_i,
  input  logic signed [CoordBits-1:0]   sy_i,
  input  logic signed [CoordBits-1:0]   ex_i,
  input  logic signed [CoordBits-1:0]   ey_i,
  input  logic signed [CoordBits-1:0]   px_i,
  input  logic signed [CoordBits-1:0]   py_i,
  output logic [2*CoordBits+2:0]        dist_o
);
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned CW = 2 * PW;
  localparam int unsigned QW = 2 * CoordBits + 3;
  localparam int unsigned NLAT = QW;

  // Stage 1: differences
  logic signed [DW-1:0] dx_q, dy_q, rx_q, ry_q, qx_q, qy_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= DW'(ex_i) - DW'(sx_i);
      dy_q <= DW'(ey_i) - DW'(sy_i);
      rx_q <= DW'(px_i) - DW'(sx_i);
      ry_q <= DW'(py_i) - DW'(sy_i);
      qx_q <= DW'(px_i) - DW'(ex_i);
      qy_q <= DW'(py_i) - DW'(ey_i);
    end
  end

  // Stage 2: products
  logic signed [PW-1:0] len_q, t_q, cr_q, da_q, db_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= PW'(dx_q * dx_q) + PW'(dy_q * dy_q);
      t_q   <= PW'(rx_q * dx_q) + PW'(ry_q * dy_q);
      cr_q  <= PW'(rx_q * dy_q) - PW'(ry_q * dx_q);
      da_q  <= PW'(rx_q * rx_q) + PW'(ry_q * ry_q);
      db_q  <= PW'(qx_q * qx_q) + PW'(qy_q * qy_q);
    end
  end

  // Stage 3: decide path, take |cross|, pick nearer endpoint distance
  logic            perp_q;
  logic [PW-1:0]   mag_q, l3_q, e3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      perp_q <= (t_q > 0) && (t_q < len_q);
      mag_q  <= cr_q[PW-1] ? PW'(-cr_q) : PW'(cr_q);
      l3_q   <= PW'(len_q);
      e3_q   <= (da_q < db_q) ? PW'(da_q) : PW'(db_q);
    end
  end

  // Stage 4: square of cross magnitude
  logic            perp4_q;
  logic [CW-1:0]   sq_q;
  logic [PW-1:0]   l4_q, e4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      perp4_q <= perp_q;
      sq_q    <= CW'(mag_q) * CW'(mag_q);
      l4_q    <= l3_q;
      e4_q    <= e3_q;
    end
  end

  // Restoring divider: one quotient bit per stage, QW-bit integer quotient.
  logic [CW-1:0] rem_q  [1:NLAT];
  logic [QW-1:0] quo_q  [1:NLAT];
  logic [PW-1:0] den_q  [1:NLAT];
  logic [PW-1:0] alt_q  [1:NLAT];
  logic          perp_p [1:NLAT];

  for (genvar g = 0; g < NLAT; g++) begin : g_div
    localparam int unsigned SH = QW - 1 - g;
    logic [CW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [PW-1:0] den_in;
    logic [PW-1:0] alt_in;
    logic          perp_in;
    logic [CW:0]   sub_d;
    logic          ge_d;
    if (g == 0) begin : g_head
      assign rem_in  = sq_q;
      assign quo_in  = '0;
      assign den_in  = l4_q;
      assign alt_in  = e4_q;
      assign perp_in = perp4_q;
    end else begin : g_body
      assign rem_in  = rem_q[g];
      assign quo_in  = quo_q[g];
      assign den_in  = den_q[g];
      assign alt_in  = alt_q[g];
      assign perp_in = perp_p[g];
    end
    assign sub_d = {1'b0, rem_in} - ({(CW + 1 - PW)'(0), den_in} << SH);
    assign ge_d  = !sub_d[CW];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= ge_d ? sub_d[CW-1:0] : rem_in;
        quo_q[g+1]  <= {quo_in[QW-2:0], ge_d};
        den_q[g+1]  <= den_in;
        alt_q[g+1]  <= alt_in;
        perp_p[g+1] <= perp_in;
      end
    end
  end

  assign dist_o = perp_p[NLAT] ? quo_q[NLAT] : QW'(alt_q[NLAT]);
endmodule

### design/segment_segment_distance_sq_top.sv
`timescale 1ns / 1ps
// Segment-to-segment squared distance, streaming top level.
// Depends on ssd_pkg and ssd_pt_seg.
// Accepts one segment pair per cycle while the output is not stalled; the
// pipeline depth is set mostly by the bit-per-stage restoring divider for the
// perpendicular distance. The whole pipeline holds while the output is stalled.
module segment_segment_distance_sq_top #(
  parameter int unsigned COORD_BITS = ssd_pkg::CoordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]    s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // dist_sq (36), then zero fill
  output logic [39:0]                m_axis_tdata,
  // crossing
  output logic                       m_axis_tuser
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned QW = 2 * CB + 3;
  localparam int unsigned LAT = QW + 5;
  localparam int unsigned DB = ssd_pkg::DistBits;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [CB-1:0] c [8];
  for (genvar i = 0; i < 8; i++) begin : g_f
    assign c[i] = s_axis_tdata[i*CB +: CB];
  end

  logic [QW-1:0] d0, d1, d2, d3;
  ssd_pt_seg #(.CoordBits(CB)) u_p0 (.clk_i, .en_i(en), .sx_i(c[0]), .sy_i(c[1]),
    .ex_i(c[2]), .ey_i(c[3]), .px_i(c[4]), .py_i(c[5]), .dist_o(d0));
  ssd_pt_seg #(.CoordBits(CB)) u_p1 (.clk_i, .en_i(en), .sx_i(c[0]), .sy_i(c[1]),
    .ex_i(c[2]), .ey_i(c[3]), .px_i(c[6]), .py_i(c[7]), .dist_o(d1));
  ssd_pt_seg #(.CoordBits(CB)) u_p2 (.clk_i, .en_i(en), .sx_i(c[4]), .sy_i(c[5]),
    .ex_i(c[6]), .ey_i(c[7]), .px_i(c[0]), .py_i(c[1]), .dist_o(d2));
  ssd_pt_seg #(.CoordBits(CB)) u_p3 (.clk_i, .en_i(en), .sx_i(c[4]), .sy_i(c[5]),
    .ex_i(c[6]), .ey_i(c[7]), .px_i(c[2]), .py_i(c[3]), .dist_o(d3));

  // Crossing test: differences, cross products, sign compare.
  logic signed [DW-1:0] xa_q [8];
  always_ff @(posedge clk_i) begin
    if (en) begin
      // B start rel. A start, B direction, B start rel. A end, A start rel. B start
      xa_q[0] <= DW'(c[4]) - DW'(c[0]); xa_q[1] <= DW'(c[5]) - DW'(c[1]);
      xa_q[2] <= DW'(c[6]) - DW'(c[4]); xa_q[3] <= DW'(c[7]) - DW'(c[5]);
      xa_q[4] <= DW'(c[4]) - DW'(c[2]); xa_q[5] <= DW'(c[5]) - DW'(c[3]);
      xa_q[6] <= DW'(c[0]) - DW'(c[4]); xa_q[7] <= DW'(c[1]) - DW'(c[5]);
    end
  end
  // derived: (A2-A1),(A1-B2); cross(o,p,q)=(p-o)x(q-o)=(p-o)x(q-p)
  logic signed [DW-1:0] ax_q, ay_q, ux_q, uy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= DW'(c[2]) - DW'(c[0]); ay_q <= DW'(c[3]) - DW'(c[1]);
      ux_q <= DW'(c[0]) - DW'(c[6]); uy_q <= DW'(c[1]) - DW'(c[7]);
    end
  end
  logic signed [PW-1:0] k1_q, k2_q, k3_q, k4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q <= PW'(xa_q[0] * xa_q[3]) - PW'(xa_q[2] * xa_q[1]);
      k2_q <= PW'(xa_q[4] * xa_q[3]) - PW'(xa_q[2] * xa_q[5]);
      k3_q <= PW'(xa_q[6] * ay_q) - PW'(ax_q * xa_q[7]);
      k4_q <= PW'(ux_q * ay_q) - PW'(ax_q * uy_q);
    end
  end
  function automatic logic [1:0] sg(logic signed [PW-1:0] v);
    return (v == '0) ? 2'd0 : (v[PW-1] ? 2'd2 : 2'd1);
  endfunction
  logic [LAT-4:0] xp_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q <= {xp_q[LAT-5:0], (sg(k1_q) != sg(k2_q)) && (sg(k3_q) != sg(k4_q))};
    end
  end

  logic [QW-1:0] m01_q, m23_q;
  logic          xq_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      m01_q <= (d1 < d0) ? d1 : d0;
      m23_q <= (d3 < d2) ? d3 : d2;
      xq_q  <= xp_q[LAT-4];
    end
  end
  logic [QW-1:0] mn;
  assign mn = (m23_q < m01_q) ? m23_q : m01_q;

  logic [LAT:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-1:0], s_axis_tvalid};
    end
  end

  logic [DB-1:0] dist_q;
  logic          cr_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q   <= xq_q;
      if (xq_q) dist_q <= '0;
      else if (QW > DB && (mn >> DB) != '0) dist_q <= '1;
      else dist_q <= DB'(mn);
    end
  end

  assign m_axis_tvalid = v_q[LAT];
  assign m_axis_tdata  = {4'b0, dist_q};
  assign m_axis_tuser  = cr_q;
endmodule

### design/ssd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the segment distance top level, with its bind.
// Depends on segment_segment_distance_sq_top.
module ssd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_cross_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("crossing with nonzero distance");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
endmodule

bind segment_segment_distance_sq_top ssd_checker u_ssd_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser);
